@@ design/srbf_pkg.sv @@
// srbf_pkg: shared types, codes and constants of the block-fetch client.
// No dependencies; used by srbf_core and selective_repeat_block_fetch.
`timescale 1ns / 1ps
`default_nettype none

package srbf_pkg;

  localparam int NUM_PIECES_DEF = 8;
  localparam int POS_BITS_DEF   = 40;

  localparam int FILE_ID_W = 31;
  localparam int MASK_W    = 8;
  localparam int ATT_W     = 4;
  localparam int SLOT_W    = 3;

  localparam logic [ATT_W-1:0] RETRY_RESET = 4'd5;
  localparam logic [ATT_W-1:0] ATTEMPT_MAX = 4'hF;

  // configuration register indexes (byte address = 4 * index)
  localparam logic CFG_FILE_ID = 1'b0;
  localparam logic CFG_RETRY   = 1'b1;

  typedef enum logic [2:0] {
    FN_TICK  = 3'd0,
    FN_UP    = 3'd1,
    FN_DOWN  = 3'd2,
    FN_PKT   = 3'd3,
    FN_FETCH = 3'd4
  } func_t;

  localparam logic [1:0] PK_PARAMS = 2'd0;
  localparam logic [1:0] PK_DATA   = 2'd1;

  typedef enum logic [2:0] {
    EV_NAME    = 3'd0,
    EV_QUERY   = 3'd1,
    EV_PARAMS  = 3'd2,
    EV_PIECE   = 3'd3,
    EV_NOTHING = 3'd4,
    EV_FAIL    = 3'd5,
    EV_PROXY   = 3'd6,
    EV_LOST    = 3'd7
  } ev_t;

  typedef enum logic [3:0] {
    PH_ASK   = 4'b0001,
    PH_KNOWN = 4'b0010,
    PH_FETCH = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [ATT_W-1:0]   attempts;
    logic               ticking;
    logic [MASK_W-1:0]  wanted;
    logic [MASK_W-1:0]  received;
  } srbf_state_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [1:0]         kind;
    logic [MASK_W-1:0]  pmask;
    logic [MASK_W-1:0]  nmask;
    logic               conn;
    logic               proxy;
  } srbf_item_t;

  typedef struct packed {
    logic               has;
    ev_t                ev;
    logic [MASK_W-1:0]  req_mask;
    logic [SLOT_W-1:0]  slot;
    logic               piece_valid;
    logic               done;
  } srbf_res_t;

endpackage : srbf_pkg

`default_nettype wire

@@ design/selective_repeat_block_fetch.sv @@
// selective_repeat_block_fetch: top level of the block-fetch client.
// Depends on srbf_pkg and srbf_core; holds APB registers, state and the two item stages.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_valid/in_ready): one event per transfer - retry tick,
//   channel up, channel down, decoded packet, or a fetch-block request.
//   Result channel (out_valid/out_ready): zero or one result per event; events
//   that cause nothing (early ticks, ignored packets, unused codes) are dropped.
//   APB port: file_id at byte address 0, retry_limit at 4; pready is always
//   high, reads return the register. Write only while the block is idle.
// Timing
//   An accepted event lands in an input register; when the result register is
//   free or being emptied, srbf_core runs it against the state and loads the
//   result register. One event can be taken every cycle while out_ready stays
//   high: the state update in srbf_core is the only loop, so throughput is
//   1 item/cycle.
// Stalls
//   While the result register is full and out_ready is low, the input register
//   holds; in_ready drops only when both stages are occupied.
// Reset
//   rst_n (synchronous, active low): phase back to asking for parameters,
//   counters and masks cleared, timer stopped, file_id 0, retry_limit 5.
module selective_repeat_block_fetch
  import srbf_pkg::*;
#(
  parameter int NUM_PIECES = NUM_PIECES_DEF,
  parameter int POS_BITS   = POS_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // APB configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           in_func,
  input  wire logic [1:0]           in_pkt_kind,
  input  wire logic [POS_BITS-1:0]  in_pkt_pos,
  input  wire logic [MASK_W-1:0]    in_pkt_mask,
  input  wire logic [POS_BITS-1:0]  in_new_block,
  input  wire logic [MASK_W-1:0]    in_new_mask,
  input  wire logic                 in_chan_connected,
  input  wire logic                 in_chan_via_proxy,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_event_res,
  output logic [FILE_ID_W-1:0]      out_req_file_id,
  output logic [POS_BITS-1:0]       out_req_pos,
  output logic [MASK_W-1:0]         out_req_mask,
  output logic [POS_BITS-1:0]       out_file_length,
  output logic [SLOT_W-1:0]         out_piece_slot,
  output logic                      out_piece_valid,
  output logic [MASK_W-1:0]         out_got_mask,
  output logic                      out_block_done
);

  // ---------------- configuration registers ----------------
  logic [FILE_ID_W-1:0] file_id_r;
  logic [ATT_W-1:0]     retry_limit_r;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_id_r     <= '0;
      retry_limit_r <= RETRY_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_FILE_ID) begin
        file_id_r <= pwdata[FILE_ID_W-1:0];
      end else begin
        retry_limit_r <= pwdata[ATT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == CFG_RETRY) begin
      prdata = {{(32-ATT_W){1'b0}}, retry_limit_r};
    end else begin
      prdata = {1'b0, file_id_r};
    end
  end

  // ---------------- input stage ----------------
  logic                in_vld_r;
  srbf_item_t          item_r;
  logic [POS_BITS-1:0] pkt_pos_r;
  logic [POS_BITS-1:0] new_block_r;
  logic                adv;      // input stage hands its event to the core

  assign adv      = in_vld_r && (!out_valid || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.func  <= in_func;
      item_r.kind  <= in_pkt_kind;
      item_r.pmask <= in_pkt_mask;
      item_r.nmask <= in_new_mask;
      item_r.conn  <= in_chan_connected;
      item_r.proxy <= in_chan_via_proxy;
      pkt_pos_r    <= in_pkt_pos;
      new_block_r  <= in_new_block;
    end
  end

  // ---------------- protocol state ----------------
  srbf_state_t         st_r,     st_nxt;
  logic [POS_BITS-1:0] block_r,  block_nxt;
  logic [POS_BITS-1:0] length_r, length_nxt;
  srbf_res_t           res;
  logic [POS_BITS-1:0] req_pos;

  srbf_core #(
    .NUM_PIECES (NUM_PIECES),
    .POS_BITS   (POS_BITS)
  ) u_core (
    .st          (st_r),
    .block       (block_r),
    .length      (length_r),
    .item        (item_r),
    .pkt_pos     (pkt_pos_r),
    .new_block   (new_block_r),
    .retry_limit (retry_limit_r),
    .st_nxt      (st_nxt),
    .block_nxt   (block_nxt),
    .length_nxt  (length_nxt),
    .res         (res),
    .req_pos     (req_pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase    <= PH_ASK;
      st_r.attempts <= '0;
      st_r.ticking  <= 1'b0;
      st_r.wanted   <= '0;
      st_r.received <= '0;
      block_r       <= '0;
      length_r      <= '0;
    end else if (adv) begin
      st_r     <= st_nxt;
      block_r  <= block_nxt;
      length_r <= length_nxt;
    end
  end

  // ---------------- result register ----------------
  logic out_valid_r;
  logic send_ev;

  assign out_valid = out_valid_r;
  assign send_ev   = res.ev == EV_NAME || res.ev == EV_QUERY;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.has;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.has) begin
      out_event_res   <= res.ev;
      out_req_file_id <= send_ev ? file_id_r : '0;
      out_req_pos     <= req_pos;
      out_req_mask    <= res.req_mask;
      out_file_length <= length_nxt;
      out_piece_slot  <= res.slot;
      out_piece_valid <= res.piece_valid;
      out_got_mask    <= st_nxt.received;
      out_block_done  <= res.done;
    end
  end

  // ---------------- assertions ----------------
  // a query always enters the fetch phase
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.has && res.ev == EV_QUERY |=> st_r.phase == PH_FETCH)
    else $error("query did not enter fetch phase");

  // a new fetch clears received pieces and counts one attempt
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && item_r.func == FN_FETCH && res.ev == EV_QUERY
    |=> st_r.received == '0 && st_r.attempts == 4'd1)
    else $error("fetch did not restart piece tracking");

  // a query never asks for an empty set of pieces
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_res == EV_QUERY |-> out_req_mask != '0)
    else $error("query with empty piece mask");

endmodule : selective_repeat_block_fetch

`default_nettype wire

@@ design/srbf_core.sv @@
// srbf_core: per-event decision logic (next state and result) of the fetch client.
// Depends on srbf_pkg. Purely combinational; registers live in the top level.
`timescale 1ns / 1ps
`default_nettype none

module srbf_core
  import srbf_pkg::*;
#(
  parameter int NUM_PIECES = NUM_PIECES_DEF,
  parameter int POS_BITS   = POS_BITS_DEF
) (
  input  var srbf_state_t        st,
  input  var logic [POS_BITS-1:0] block,
  input  var logic [POS_BITS-1:0] length,
  input  var srbf_item_t         item,
  input  var logic [POS_BITS-1:0] pkt_pos,
  input  var logic [POS_BITS-1:0] new_block,
  input  var logic [ATT_W-1:0]   retry_limit,
  output srbf_state_t            st_nxt,
  output logic [POS_BITS-1:0]    block_nxt,
  output logic [POS_BITS-1:0]    length_nxt,
  output srbf_res_t              res,
  output logic [POS_BITS-1:0]    req_pos
);

  localparam logic [MASK_W-1:0] PIECE_MSK = MASK_W'((1 << NUM_PIECES) - 1);

  logic [MASK_W-1:0] pmask;
  logic [MASK_W-1:0] nmask;
  logic [SLOT_W-1:0] low_slot;
  logic              low_any;

  assign pmask = item.pmask & PIECE_MSK;
  assign nmask = item.nmask & PIECE_MSK;

  // lowest set bit of the packet mask
  always_comb begin
    low_slot = '0;
    low_any  = 1'b0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (pmask[i]) begin
        low_slot = SLOT_W'(i);
        low_any  = 1'b1;
      end
    end
  end

  always_comb begin
    st_nxt          = st;
    block_nxt       = block;
    length_nxt      = length;
    res.has         = 1'b0;
    res.ev          = EV_NAME;
    res.slot        = '0;
    res.piece_valid = 1'b0;
    res.done        = 1'b0;
    res.req_mask    = '0;
    req_pos         = '0;

    unique case (item.func)
      FN_TICK: begin
        if (st.ticking) begin
          if (st.attempts > retry_limit) begin
            res.has = 1'b1;
            res.ev  = EV_FAIL;
          end else if (st.phase == PH_ASK) begin
            res.has = 1'b1;
            res.ev  = EV_NAME;
          end else if (st.phase == PH_FETCH) begin
            res.has = 1'b1;
            res.ev  = EV_QUERY;
          end
        end
      end
      FN_UP: begin
        st_nxt.ticking = 1'b1;
        res.has        = 1'b1;
        res.ev         = EV_NAME;
      end
      FN_DOWN: begin
        res.has = 1'b1;
        res.ev  = (st.phase == PH_ASK && item.conn && !item.proxy) ? EV_PROXY : EV_LOST;
      end
      FN_PKT: begin
        if (st.phase == PH_ASK && item.kind == PK_PARAMS) begin
          length_nxt      = pkt_pos;
          st_nxt.phase    = PH_KNOWN;
          st_nxt.attempts = '0;
          res.has         = 1'b1;
          res.ev          = EV_PARAMS;
        end else if (st.phase == PH_FETCH && item.kind == PK_DATA && pkt_pos == block) begin
          if (low_any) begin
            st_nxt.received[low_slot] = 1'b1;
          end
          st_nxt.attempts = '0;
          res.has         = 1'b1;
          res.ev          = EV_PIECE;
          res.slot        = low_slot;
          res.piece_valid = low_any;
          if ((st.wanted & st_nxt.received) == st.wanted) begin
            st_nxt.phase = PH_DONE;
            res.done     = 1'b1;
          end
        end
      end
      FN_FETCH: begin
        res.has = 1'b1;
        if (nmask == '0) begin
          st_nxt.phase = PH_DONE;
          res.ev       = EV_NOTHING;
        end else begin
          block_nxt       = new_block;
          st_nxt.wanted   = nmask;
          st_nxt.received = '0;
          st_nxt.attempts = '0;
          res.ev          = EV_QUERY;
        end
      end
      default: begin
      end
    endcase

    // every send is one attempt; a query also enters the fetch phase
    if (res.has && (res.ev == EV_NAME || res.ev == EV_QUERY)) begin
      if (st_nxt.attempts != ATTEMPT_MAX) begin
        st_nxt.attempts = st_nxt.attempts + 4'd1;
      end
    end
    if (res.has && res.ev == EV_QUERY) begin
      st_nxt.phase = PH_FETCH;
      req_pos      = block_nxt;
      res.req_mask = st_nxt.wanted ^ st_nxt.received;
    end
  end

endmodule : srbf_core

`default_nettype wire

@@ tb/sv/tb_selective_repeat_block_fetch.sv @@
// tb_selective_repeat_block_fetch: self-checking bench for the block-fetch client.
// Depends on srbf_pkg and selective_repeat_block_fetch; drives event transfers,
// programs the APB registers and checks every result against an in-bench model.
`timescale 1ns / 1ps

module tb_selective_repeat_block_fetch;
  import srbf_pkg::*;

  localparam int POS_W = POS_BITS_DEF;

  // kind codes not named in the package: "other" packet, plus the spare 2-bit code
  localparam logic [1:0] PK_OTHER = 2'd2;
  // 3-bit func space; codes above FN_FETCH are unused and dropped by the block
  localparam int FUNC_CODES = 8;
  // enough back-to-back ticks to saturate the attempt counter from zero
  localparam int TICK_BURST = int'(ATTEMPT_MAX) + 1;
  // result passes the input and result registers after its transfer; pad generously
  localparam int DRAIN_CYCLES = 8;
  // cycles with no transfer on either channel before the run is declared hung
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [2:0]           func;
    logic [1:0]           kind;
    logic [POS_W-1:0]     pkt_pos;
    logic [MASK_W-1:0]    pkt_mask;
    logic [POS_W-1:0]     new_block;
    logic [MASK_W-1:0]    new_mask;
    logic                 conn;
    logic                 proxy;
  } fetch_event_t;

  typedef struct packed {
    logic [2:0]           ev;
    logic [FILE_ID_W-1:0] file_id;
    logic [POS_W-1:0]     pos;
    logic [MASK_W-1:0]    req_mask;
    logic [POS_W-1:0]     file_len;
    logic [SLOT_W-1:0]    slot;
    logic                 piece_valid;
    logic [MASK_W-1:0]    got;
    logic                 done;
  } fetch_result_t;

  // ---------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           in_func = '0;
  logic [1:0]           in_pkt_kind = '0;
  logic [POS_W-1:0]     in_pkt_pos = '0;
  logic [MASK_W-1:0]    in_pkt_mask = '0;
  logic [POS_W-1:0]     in_new_block = '0;
  logic [MASK_W-1:0]    in_new_mask = '0;
  logic                 in_chan_connected = 1'b0;
  logic                 in_chan_via_proxy = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_event_res;
  logic [FILE_ID_W-1:0] out_req_file_id;
  logic [POS_W-1:0]     out_req_pos;
  logic [MASK_W-1:0]    out_req_mask;
  logic [POS_W-1:0]     out_file_length;
  logic [SLOT_W-1:0]    out_piece_slot;
  logic                 out_piece_valid;
  logic [MASK_W-1:0]    out_got_mask;
  logic                 out_block_done;

  selective_repeat_block_fetch i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_pkt_kind       (in_pkt_kind),
    .in_pkt_pos        (in_pkt_pos),
    .in_pkt_mask       (in_pkt_mask),
    .in_new_block      (in_new_block),
    .in_new_mask       (in_new_mask),
    .in_chan_connected (in_chan_connected),
    .in_chan_via_proxy (in_chan_via_proxy),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_res     (out_event_res),
    .out_req_file_id   (out_req_file_id),
    .out_req_pos       (out_req_pos),
    .out_req_mask      (out_req_mask),
    .out_file_length   (out_file_length),
    .out_piece_slot    (out_piece_slot),
    .out_piece_valid   (out_piece_valid),
    .out_got_mask      (out_got_mask),
    .out_block_done    (out_block_done)
  );

  // 4 ns period
  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // ---------------------------------------------------------------------------
  // Protocol model: shadow registers and client state, reset values as the RTL
  // ---------------------------------------------------------------------------
  logic [FILE_ID_W-1:0] file_id_reg = '0;
  logic [ATT_W-1:0]     retry_lim = RETRY_RESET;
  phase_t               fetch_phase = PH_ASK;
  logic [ATT_W-1:0]     attempt_cnt = '0;
  logic                 timer_on = 1'b0;
  logic [POS_W-1:0]     cur_block = '0;
  logic [MASK_W-1:0]    want_mask = '0;
  logic [MASK_W-1:0]    have_mask = '0;
  logic [POS_W-1:0]     file_len = '0;

  fetch_result_t        pending_results[$];
  int                   errors = 0;
  int                   send_idle_pct = 0;
  int                   rcv_idle_pct = 0;
  int                   quiet_cycles = 0;

  // what the generator believes is being fetched; kept apart from the model
  logic [POS_W-1:0]     stim_block = '0;
  logic [MASK_W-1:0]    stim_want = '0;
  logic [MASK_W-1:0]    stim_sent = '0;

  // Outgoing request: name request, or data query on the current block.
  // Either one is an attempt; a query also (re)enters the fetching phase.
  function automatic void issue_request(input bit query, output fetch_result_t r);
    r = '0;
    r.file_id = file_id_reg;
    if (query) begin
      r.ev = EV_QUERY;
      r.pos = cur_block;
      r.req_mask = want_mask ^ have_mask;
      fetch_phase = PH_FETCH;
    end else begin
      r.ev = EV_NAME;
    end
    if (attempt_cnt != ATTEMPT_MAX) attempt_cnt = attempt_cnt + 1'b1;
  endfunction

  // Advances the model by one event; returns 1 when the event yields a result.
  function automatic bit predict_event(input fetch_event_t e, output fetch_result_t r);
    bit has;
    has = 1'b1;
    r = '0;
    case (e.func)
      FN_TICK: begin
        // timer not started yet: tick is dropped
        if (!timer_on) has = 1'b0;
        else if (attempt_cnt > retry_lim) r.ev = EV_FAIL;
        else if (fetch_phase == PH_ASK) issue_request(1'b0, r);
        else if (fetch_phase == PH_FETCH) issue_request(1'b1, r);
        else has = 1'b0;
      end
      FN_UP: begin
        timer_on = 1'b1;
        issue_request(1'b0, r);
      end
      FN_DOWN: begin
        // proxy fallback only while still asking, and only for a direct link
        r.ev = (fetch_phase == PH_ASK && e.conn && !e.proxy) ? EV_PROXY : EV_LOST;
      end
      FN_PKT: begin
        if (fetch_phase == PH_ASK && e.kind == PK_PARAMS) begin
          file_len = e.pkt_pos;
          fetch_phase = PH_KNOWN;
          attempt_cnt = '0;
          r.ev = EV_PARAMS;
        end else if (fetch_phase == PH_FETCH && e.kind == PK_DATA &&
                     e.pkt_pos == cur_block) begin
          // lowest set mask bit names the piece; an empty mask still counts
          for (int i = MASK_W - 1; i >= 0; i--) begin
            if (e.pkt_mask[i]) begin
              r.slot = SLOT_W'(i);
              r.piece_valid = 1'b1;
            end
          end
          if (r.piece_valid) have_mask[r.slot] = 1'b1;
          attempt_cnt = '0;
          if ((want_mask & have_mask) == want_mask) begin
            fetch_phase = PH_DONE;
            r.done = 1'b1;
          end
          r.ev = EV_PIECE;
        end else begin
          has = 1'b0;
        end
      end
      FN_FETCH: begin
        if (e.new_mask == '0) begin
          fetch_phase = PH_DONE;
          r.ev = EV_NOTHING;
        end else begin
          cur_block = e.new_block;
          want_mask = e.new_mask;
          have_mask = '0;
          attempt_cnt = '0;
          issue_request(1'b1, r);
        end
      end
      default: has = 1'b0;
    endcase
    // length and received mask ride along in every result
    r.file_len = file_len;
    r.got = have_mask;
    return has;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard. Results are checked before the input side is sampled, so an
  // event accepted on this edge can never be matched against a result that
  // leaves on the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    fetch_result_t exp_r;
    fetch_result_t pred;
    fetch_event_t  acc;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected, event_res %0d", out_event_res);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("event_res",   64'(exp_r.ev),          64'(out_event_res));
          check_field("req_file_id", 64'(exp_r.file_id),     64'(out_req_file_id));
          check_field("req_pos",     64'(exp_r.pos),         64'(out_req_pos));
          check_field("req_mask",    64'(exp_r.req_mask),    64'(out_req_mask));
          check_field("file_length", 64'(exp_r.file_len),    64'(out_file_length));
          check_field("piece_slot",  64'(exp_r.slot),        64'(out_piece_slot));
          check_field("piece_valid", 64'(exp_r.piece_valid), 64'(out_piece_valid));
          check_field("got_mask",    64'(exp_r.got),         64'(out_got_mask));
          check_field("block_done",  64'(exp_r.done),        64'(out_block_done));
        end
      end
      if (in_valid && in_ready) begin
        acc.func      = in_func;
        acc.kind      = in_pkt_kind;
        acc.pkt_pos   = in_pkt_pos;
        acc.pkt_mask  = in_pkt_mask;
        acc.new_block = in_new_block;
        acc.new_mask  = in_new_mask;
        acc.conn      = in_chan_connected;
        acc.proxy     = in_chan_via_proxy;
        if (predict_event(acc, pred)) pending_results.push_back(pred);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // watchdog: any transfer on either channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_results.size());
      $display("tb_selective_repeat_block_fetch: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // 40-bit position with the extremes weighted in
  function automatic logic [POS_W-1:0] rand_pos();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return w[POS_W-1:0];
    endcase
  endfunction

  // One event transfer. Entered and left on a rising edge; valid is left high
  // so back-to-back transfers never drop it. Each cycle before the transfer
  // idles with the sender's idle percentage.
  task automatic send_event(input fetch_event_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= e.func;
    in_pkt_kind       <= e.kind;
    in_pkt_pos        <= e.pkt_pos;
    in_pkt_mask       <= e.pkt_mask;
    in_new_block      <= e.new_block;
    in_new_mask       <= e.new_mask;
    in_chan_connected <= e.conn;
    in_chan_via_proxy <= e.proxy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Builds an event with random filler; only the fields that matter for the
  // given func take the supplied values (pos/mask are the block and mask on fetch).
  task automatic post(input logic [2:0] fn, input logic [1:0] kind,
                      input logic [POS_W-1:0] pos, input logic [MASK_W-1:0] mask,
                      input logic conn, input logic proxy);
    fetch_event_t e;
    e.func      = fn;
    e.kind      = 2'($urandom);
    e.pkt_pos   = rand_pos();
    e.pkt_mask  = MASK_W'($urandom);
    e.new_block = rand_pos();
    e.new_mask  = MASK_W'($urandom);
    e.conn      = 1'($urandom);
    e.proxy     = 1'($urandom);
    case (fn)
      FN_PKT: begin
        e.kind = kind;
        e.pkt_pos = pos;
        e.pkt_mask = mask;
      end
      FN_FETCH: begin
        e.new_block = pos;
        e.new_mask = mask;
      end
      FN_DOWN: begin
        e.conn = conn;
        e.proxy = proxy;
      end
      default: ;
    endcase
    send_event(e);
  endtask

  // Waits until every expected result is out plus the pipeline depth, so
  // dropped events are surely through too.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write followed directly by a read-back of the same register
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] keep;
    keep = (idx == CFG_FILE_ID) ? 32'((64'd1 << FILE_ID_W) - 1) :
                                  32'((64'd1 << ATT_W) - 1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register written on this edge; go straight into the read setup
    if (idx == CFG_FILE_ID) file_id_reg = value[FILE_ID_W-1:0];
    else retry_lim = value[ATT_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rd = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("prdata", 64'(value & keep), 64'(rd & keep));
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests (reset register values: file_id 0, retry_limit 5)
  // ---------------------------------------------------------------------------
  // tick before channel up is dropped; channel down before parameters
  task automatic test_early_events();
    post(FN_TICK, '0, '0, '0, 1'b0, 1'b0);
    post(FN_DOWN, '0, '0, '0, 1'b1, 1'b0);   // direct link: proxy fallback
    post(FN_DOWN, '0, '0, '0, 1'b1, 1'b1);   // already on proxy: lost
  endtask

  // channel up + five ticks send six name requests; the next tick fails
  task automatic test_retry_limit();
    post(FN_UP, '0, '0, '0, 1'b0, 1'b0);
    repeat (6) post(FN_TICK, '0, '0, '0, 1'b0, 1'b0);
  endtask

  task automatic test_param_answer();
    post(FN_PKT, PK_DATA, '0, '1, 1'b0, 1'b0);       // wrong kind while asking
    post(FN_PKT, PK_PARAMS, '1, '0, 1'b0, 1'b0);     // max file length
    post(FN_TICK, '0, '0, '0, 1'b0, 1'b0);           // params known: silent
    post(FN_PKT, PK_PARAMS, '0, '0, 1'b0, 1'b0);     // no longer asking
  endtask

  task automatic test_block_fetch();
    post(FN_FETCH, '0, '1, '1, 1'b0, 1'b0);
    post(FN_PKT, PK_DATA, {{(POS_W-1){1'b1}}, 1'b0}, 8'h01, 1'b0, 1'b0); // other block
    post(FN_PKT, PK_OTHER, '1, 8'h01, 1'b0, 1'b0);   // other kind
    post(FN_PKT, PK_DATA, '1, 8'h00, 1'b0, 1'b0);    // empty mask
    post(FN_PKT, PK_DATA, '1, 8'h80, 1'b0, 1'b0);    // top slot
    post(FN_PKT, PK_DATA, '1, 8'hFE, 1'b0, 1'b0);    // lowest bit wins
    post(FN_TICK, '0, '0, '0, 1'b0, 1'b0);           // re-query, remaining pieces
    post(FN_FETCH, '0, '0, 8'h01, 1'b0, 1'b0);       // block 0, one piece
    post(FN_PKT, PK_DATA, '0, 8'h01, 1'b0, 1'b0);    // completes the block
    post(FN_TICK, '0, '0, '0, 1'b0, 1'b0);           // done: silent
    post(FN_FETCH, '0, '1, '0, 1'b0, 1'b0);          // nothing to fetch
  endtask

  task automatic test_ignored_codes();
    for (int f = FN_FETCH + 1; f < FUNC_CODES; f++) post(3'(f), '0, '0, '0, 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic, mostly well-formed fetch exchanges on the block the
  // generator last asked for, mixed with ticks, link events and noise.
  // ---------------------------------------------------------------------------
  task automatic test_random(input int n_items, input int s_pct, input int r_pct,
                             input logic [FILE_ID_W-1:0] fid, input logic [ATT_W-1:0] lim);
    int                count;
    int                pick;
    int                k;
    logic [MASK_W-1:0] left;
    logic [MASK_W-1:0] pm;
    logic [POS_W-1:0]  blk_v;
    logic [1:0]        kind_v;
    drain();
    write_reg(CFG_FILE_ID, 32'(fid));
    write_reg(CFG_RETRY, 32'(lim));
    send_idle_pct = s_pct;
    rcv_idle_pct = r_pct;
    count = 0;
    while (count < n_items) begin
      pick = $urandom_range(99);
      count++;
      if (pick < 14) begin
        post(FN_TICK, '0, '0, '0, 1'b0, 1'b0);
      end else if (pick < 18) begin
        post(FN_UP, '0, '0, '0, 1'b0, 1'b0);
      end else if (pick < 23) begin
        post(FN_DOWN, '0, '0, '0, 1'($urandom), 1'($urandom));
      end else if (pick < 31) begin
        post(FN_PKT, PK_PARAMS, rand_pos(), MASK_W'($urandom), 1'b0, 1'b0);
      end else if (pick < 63) begin
        // data for a piece not yet delivered (repeats once all are out)
        left = stim_want & ~stim_sent;
        if (left == '0) left = (stim_want == '0) ? '1 : stim_want;
        do k = $urandom_range(MASK_W - 1); while (!left[k]);
        pm = MASK_W'($urandom);
        pm = pm << k;
        pm[k] = 1'b1;
        if ($urandom_range(19) == 0) pm = '0;
        else stim_sent[k] = 1'b1;
        post(FN_PKT, PK_DATA, stim_block, pm, 1'b0, 1'b0);
      end else if (pick < 70) begin
        // near miss: one block bit off, or a non-data kind on the right block
        if ($urandom_range(1)) begin
          blk_v = stim_block;
          blk_v[$urandom_range(POS_W - 1)] ^= 1'b1;
          post(FN_PKT, PK_DATA, blk_v, MASK_W'($urandom), 1'b0, 1'b0);
        end else begin
          kind_v = 2'($urandom);
          if (kind_v == PK_DATA) kind_v = PK_OTHER;
          post(FN_PKT, kind_v, stim_block, MASK_W'($urandom), 1'b0, 1'b0);
        end
      end else if (pick < 84) begin
        pm = MASK_W'($urandom);
        if (pm == '0) pm = '1;
        case ($urandom_range(9))
          0: pm = '0;
          1: pm = '1;
          default: ;
        endcase
        blk_v = $urandom_range(1) ? POS_W'($urandom_range(15)) : rand_pos();
        post(FN_FETCH, '0, blk_v, pm, 1'b0, 1'b0);
        if (pm != '0) begin
          stim_block = blk_v;
          stim_want = pm;
          stim_sent = '0;
        end
      end else if (pick < 86) begin
        // long tick run: walks the attempt counter past the retry limit
        repeat (TICK_BURST) post(FN_TICK, '0, '0, '0, 1'b0, 1'b0);
        count += TICK_BURST - 1;
      end else if (pick < 89) begin
        post(3'(FN_FETCH + 1 + $urandom_range(2)), '0, '0, '0, 1'b0, 1'b0);
        count--;   // dropped by the block, not counted
      end else begin
        post(3'($urandom_range(FN_FETCH)), 2'($urandom), rand_pos(), MASK_W'($urandom),
             1'($urandom), 1'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    send_idle_pct = 15;
    rcv_idle_pct = 81;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_early_events();
    test_retry_limit();
    test_param_answer();
    test_block_fetch();
    test_ignored_codes();

    // sender mostly busy, receiver mostly stalled; tightest retry limit
    test_random(600, 15, 81, FILE_ID_W'($urandom), '0);
    // sender sparse, receiver mostly ready; widest file id, retry limit 14
    test_random(600, 81, 15, '1, 4'd14);
    // full rate both ways
    test_random(600, 0, 0, '0, ATT_W'($urandom_range(1, 13)));

    drain();
    if (errors == 0) begin
      $display("tb_selective_repeat_block_fetch: PASS");
    end else begin
      $display("tb_selective_repeat_block_fetch: FAIL");
    end
    $finish;
  end

endmodule
